>>> hdl/huffman_code_table_builder_unit_assert.svh
// Assertion macros for the Huffman code table builder.
// Needs clk and arst_n in the scope of each use.
`ifndef HUFFMAN_CODE_TABLE_BUILDER_UNIT_ASSERT_SVH
`define HUFFMAN_CODE_TABLE_BUILDER_UNIT_ASSERT_SVH
// Same-cycle implication.
`define HCTB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hctb assertion failed");
// Next-cycle implication.
`define HCTB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hctb assertion failed");
`endif

>>> hdl/hctb_pkg.sv
// Shared constants, types and codes of the Huffman code table builder.
// No dependencies.
package hctb_pkg;
	localparam int ALPHABET_SIZE_DEF = 26;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int CHAR_W = 8;
	localparam int LETTER_W = 5;
	localparam int CODE_W = 25;
	localparam int LEN_W = 5;
	localparam logic [LEN_W-1:0] LEN_LIMIT = 5'd25;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_GAP = 8'd32;

	typedef struct packed {
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0] len;
	} code_entry_t;

	typedef enum logic [1:0] {
		LOP_NONE = 2'd0,
		LOP_INSERT = 2'd1,
		LOP_MERGE = 2'd2,
		LOP_CLEAR = 2'd3
	} list_op_t;

	typedef struct packed {
		list_op_t op;
	} list_ctl_t;

	typedef enum logic [8:0] {
		S_COUNT = 9'b000000001,
		S_DRAIN = 9'b000000010,
		S_SEED = 9'b000000100,
		S_MERGE = 9'b000001000,
		S_CRD = 9'b000010000,
		S_CWA = 9'b000100000,
		S_CWB = 9'b001000000,
		S_ORD = 9'b010000000,
		S_OLD = 9'b100000000
	} state_t;
endpackage

>>> hdl/hctb_in_if.sv
// Input channel: one text character per transfer.
// Depends on hctb_pkg.
interface hctb_in_if import hctb_pkg::*; ();
	logic valid;
	logic ready;
	logic [CHAR_W-1:0] char_byte;
	logic end_of_text;
	modport source (output valid, output char_byte, output end_of_text, input ready);
	modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

>>> hdl/hctb_out_if.sv
// Output channel: one code table entry per transfer.
// Depends on hctb_pkg.
interface hctb_out_if import hctb_pkg::*; ();
	logic valid;
	logic ready;
	logic [LETTER_W-1:0] letter_index;
	logic present;
	logic [CODE_W-1:0] code_bits;
	logic [LEN_W-1:0] code_length;
	logic last_entry;
	modport source (output valid, output letter_index, output present, output code_bits,
		output code_length, output last_entry, input ready);
	modport sink (input valid, input letter_index, input present, input code_bits,
		input code_length, input last_entry, output ready);
endinterface

>>> hdl/hctb_count_store.sv
// Letter count memory with read-modify-write and forwarding.
// Depends on hctb_pkg.
module hctb_count_store import hctb_pkg::*; #(
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	localparam int IW = $clog2(ALPHABET_SIZE)
) (
	input logic clk,
	input logic arst_n,
	input logic bump,
	input logic [IW-1:0] raddr,
	input logic clear,
	output logic [COUNT_WIDTH-1:0] rd_cnt,
	output logic [ALPHABET_SIZE-1:0] present
);
	logic [COUNT_WIDTH-1:0] mem [ALPHABET_SIZE];
	logic [COUNT_WIDTH-1:0] rd_q;
	logic rd_vld_q;
	logic [IW-1:0] ra_q;
	logic bump_s1;
	logic [ALPHABET_SIZE-1:0] vld_q;
	logic wr_v_q;
	logic [IW-1:0] wr_idx_q;
	logic [COUNT_WIDTH-1:0] wr_val_q;
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH-1:0] nxt;

	assign cur = (wr_v_q && wr_idx_q == ra_q) ? wr_val_q : (rd_vld_q ? rd_q : '0);
	assign nxt = (&cur) ? cur : cur + 1'b1;
	assign rd_cnt = rd_vld_q ? rd_q : '0;
	assign present = vld_q;

	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
		if (bump_s1) begin
			mem[ra_q] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		ra_q <= raddr;
		wr_idx_q <= ra_q;
		wr_val_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_s1 <= 1'b0;
			vld_q <= '0;
			wr_v_q <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			bump_s1 <= bump;
			wr_v_q <= bump_s1;
			rd_vld_q <= vld_q[raddr];
			if (clear) begin
				vld_q <= '0;
			end else if (bump_s1) begin
				vld_q[ra_q] <= 1'b1;
			end
		end
	end
endmodule

>>> hdl/hctb_sort_list.sv
// Weight-ordered list of tree nodes; insert after equal weights, merge the two heads.
// Depends on hctb_pkg.
module hctb_sort_list import hctb_pkg::*; #(
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
	parameter int WW = COUNT_WIDTH_DEF + 5,
	parameter int NW = 6,
	localparam int LW = $clog2(ALPHABET_SIZE + 1)
) (
	input logic clk,
	input logic arst_n,
	input list_ctl_t ctl,
	input logic [WW-1:0] ins_weight,
	input logic [NW-1:0] ins_id,
	output logic [LW-1:0] len,
	output logic [NW-1:0] head_a,
	output logic [NW-1:0] head_b,
	output logic [WW-1:0] head_sum
);
	logic [WW-1:0] w_q [ALPHABET_SIZE];
	logic [NW-1:0] id_q [ALPHABET_SIZE];
	logic [LW-1:0] len_q;
	logic [WW-1:0] src_w [ALPHABET_SIZE];
	logic [NW-1:0] src_id [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] le;
	logic [WW-1:0] nw;
	logic merge;
	logic [LW-1:0] keep_len;

	assign merge = (ctl.op == LOP_MERGE);
	assign len = len_q;
	assign head_a = id_q[0];
	assign head_b = id_q[1];
	assign head_sum = w_q[0] + w_q[1];
	assign nw = merge ? head_sum : ins_weight;
	assign keep_len = merge ? len_q - LW'(2) : len_q;

	always_comb begin
		for (int j = 0; j < ALPHABET_SIZE; j++) begin
			if (merge) begin
				src_w[j] = (j + 2 < ALPHABET_SIZE) ? w_q[(j + 2) % ALPHABET_SIZE] : '0;
				src_id[j] = (j + 2 < ALPHABET_SIZE) ? id_q[(j + 2) % ALPHABET_SIZE] : '0;
			end else begin
				src_w[j] = w_q[j];
				src_id[j] = id_q[j];
			end
			le[j] = (LW'(j) < keep_len) && (src_w[j] <= nw);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == LOP_INSERT || merge) begin
			for (int j = 0; j < ALPHABET_SIZE; j++) begin
				if (le[j]) begin
					w_q[j] <= src_w[j];
					id_q[j] <= src_id[j];
				end else if (j == 0 || le[(j + ALPHABET_SIZE - 1) % ALPHABET_SIZE]) begin
					w_q[j] <= nw;
					id_q[j] <= merge ? ins_id : ins_id;
				end else begin
					w_q[j] <= src_w[(j + ALPHABET_SIZE - 1) % ALPHABET_SIZE];
					id_q[j] <= src_id[(j + ALPHABET_SIZE - 1) % ALPHABET_SIZE];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (ctl.op == LOP_CLEAR) begin
			len_q <= '0;
		end else if (ctl.op != LOP_NONE) begin
			len_q <= keep_len + 1'b1;
		end
	end
endmodule

>>> hdl/hctb_node_store.sv
// Node memories: children of internal nodes and code of every node.
// Depends on hctb_pkg.
module hctb_node_store import hctb_pkg::*; #(
	parameter int NODE_SLOTS = 2 * ALPHABET_SIZE_DEF - 1,
	parameter int NW = 6
) (
	input logic clk,
	input logic ch_we,
	input logic [NW-1:0] ch_waddr,
	input logic [2*NW-1:0] ch_wdata,
	input logic [NW-1:0] ch_raddr,
	output logic [2*NW-1:0] ch_rdata,
	input logic cd_we,
	input logic [NW-1:0] cd_waddr,
	input code_entry_t cd_wdata,
	input logic [NW-1:0] cd_raddr,
	output code_entry_t cd_rdata
);
	logic [2*NW-1:0] ch_mem [NODE_SLOTS];
	code_entry_t cd_mem [NODE_SLOTS];

	always_ff @(posedge clk) begin
		ch_rdata <= ch_mem[ch_raddr];
		if (ch_we) begin
			ch_mem[ch_waddr] <= ch_wdata;
		end
	end

	always_ff @(posedge clk) begin
		cd_rdata <= cd_mem[cd_raddr];
		if (cd_we) begin
			cd_mem[cd_waddr] <= cd_wdata;
		end
	end
endmodule

>>> hdl/huffman_code_table_builder_unit.sv
// Counting: one character per cycle; each letter count is updated by a registered read-modify-write.
// Build: a drain step, a seed pass over the ALPHABET_SIZE letters, then the tree merges,
// then code assignment per internal node, one child code per write (node memory write port).
// Table: ALPHABET_SIZE entries, each one read after the previous is taken; input held off meanwhile.
// Reset clears counts, list length and control at once; node memories need no clearing.
// Depends on hctb_pkg, the channel interfaces and the submodules.
`include "huffman_code_table_builder_unit_assert.svh"
module huffman_code_table_builder_unit import hctb_pkg::*; #(
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	hctb_in_if.sink in_ch,
	hctb_out_if.source out_ch
);
	localparam int IW = $clog2(ALPHABET_SIZE);
	localparam int LW = $clog2(ALPHABET_SIZE + 1);
	localparam int NODE_SLOTS = 2 * ALPHABET_SIZE - 1;
	localparam int NW = $clog2(NODE_SLOTS);
	localparam int WW = COUNT_WIDTH + IW;

	state_t state_q;
	logic [LW-1:0] sidx_q;
	logic seed_v_s1;
	logic [IW-1:0] seed_id_s1;
	logic [NW-1:0] next_q;
	logic [NW-1:0] p_q;
	logic first_q;
	logic multi_q;
	logic [IW-1:0] oidx_q;
	logic [CODE_W-1:0] cp_q;
	logic [LEN_W-1:0] lp_q;
	logic ok_q;
	logic [NW-1:0] b_q;
	logic out_v_q;
	logic [LETTER_W-1:0] o_idx_q;
	logic o_pres_q;
	logic [CODE_W-1:0] o_bits_q;
	logic [LEN_W-1:0] o_len_q;
	logic o_last_q;

	logic accept;
	logic [CHAR_W-1:0] folded;
	logic [CHAR_W-1:0] off;
	logic letter_ok;
	logic [IW-1:0] cnt_raddr;
	logic cnt_clear;
	logic [COUNT_WIDTH-1:0] rd_cnt;
	logic [ALPHABET_SIZE-1:0] present;
	list_ctl_t lctl;
	logic [LW-1:0] lst_len;
	logic [NW-1:0] head_a;
	logic [NW-1:0] head_b;
	logic [WW-1:0] head_sum;
	logic ch_we;
	logic [2*NW-1:0] ch_rdata;
	logic cd_we;
	logic [NW-1:0] cd_waddr;
	code_entry_t cd_wdata;
	logic [NW-1:0] cd_raddr;
	code_entry_t cd_rdata;
	logic [NW-1:0] ch_a;
	logic [NW-1:0] ch_b;
	logic [CODE_W-1:0] cp_now;
	logic [LEN_W-1:0] lp_now;
	logic last_out;

	assign in_ch.ready = (state_q == S_COUNT);
	assign accept = in_ch.valid && in_ch.ready;
	assign folded = (in_ch.char_byte >= CHAR_UPPER_A && in_ch.char_byte <= CHAR_UPPER_Z)
		? in_ch.char_byte + CASE_GAP : in_ch.char_byte;
	assign off = folded - CHAR_LOWER_A;
	assign letter_ok = folded >= CHAR_LOWER_A && folded <= CHAR_LOWER_Z
		&& off < CHAR_W'(ALPHABET_SIZE);
	assign cnt_raddr = (state_q == S_COUNT) ? off[IW-1:0] : sidx_q[IW-1:0];
	assign last_out = (oidx_q == IW'(ALPHABET_SIZE - 1));
	assign cnt_clear = (state_q == S_OLD) && last_out;

	assign ch_a = ch_rdata[NW-1:0];
	assign ch_b = ch_rdata[2*NW-1:NW];
	assign cp_now = first_q ? '0 : cd_rdata.bits;
	assign lp_now = first_q ? '0 : cd_rdata.len;

	always_comb begin
		lctl.op = LOP_NONE;
		if (state_q == S_DRAIN) begin
			lctl.op = LOP_CLEAR;
		end else if (state_q == S_SEED && seed_v_s1 && rd_cnt != '0) begin
			lctl.op = LOP_INSERT;
		end else if (state_q == S_MERGE && lst_len > LW'(1)) begin
			lctl.op = LOP_MERGE;
		end
	end

	assign ch_we = (lctl.op == LOP_MERGE);
	assign cd_raddr = (state_q == S_CRD) ? p_q : NW'(oidx_q);

	always_comb begin
		cd_we = 1'b0;
		cd_waddr = ch_a;
		cd_wdata.bits = {cp_now[CODE_W-2:0], 1'b0};
		cd_wdata.len = lp_now + 1'b1;
		if (state_q == S_CWA) begin
			cd_we = lp_now < LEN_LIMIT;
		end else if (state_q == S_CWB) begin
			cd_we = ok_q;
			cd_waddr = b_q;
			cd_wdata.bits = {cp_q[CODE_W-2:0], 1'b1};
			cd_wdata.len = lp_q + 1'b1;
		end
	end

	hctb_count_store #(
		.ALPHABET_SIZE(ALPHABET_SIZE),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_count (
		.clk(clk),
		.arst_n(arst_n),
		.bump(accept && letter_ok),
		.raddr(cnt_raddr),
		.clear(cnt_clear),
		.rd_cnt(rd_cnt),
		.present(present)
	);

	hctb_sort_list #(
		.ALPHABET_SIZE(ALPHABET_SIZE),
		.WW(WW),
		.NW(NW)
	) u_list (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(lctl),
		.ins_weight((state_q == S_SEED) ? WW'(rd_cnt) : head_sum),
		.ins_id((state_q == S_SEED) ? NW'(seed_id_s1) : next_q),
		.len(lst_len),
		.head_a(head_a),
		.head_b(head_b),
		.head_sum(head_sum)
	);

	hctb_node_store #(
		.NODE_SLOTS(NODE_SLOTS),
		.NW(NW)
	) u_node (
		.clk(clk),
		.ch_we(ch_we),
		.ch_waddr(next_q),
		.ch_wdata({head_b, head_a}),
		.ch_raddr(p_q),
		.ch_rdata(ch_rdata),
		.cd_we(cd_we),
		.cd_waddr(cd_waddr),
		.cd_wdata(cd_wdata),
		.cd_raddr(cd_raddr),
		.cd_rdata(cd_rdata)
	);

	always_ff @(posedge clk) begin
		seed_id_s1 <= sidx_q[IW-1:0];
		if (state_q == S_CWA) begin
			cp_q <= cp_now;
			lp_q <= lp_now;
			ok_q <= lp_now < LEN_LIMIT;
			b_q <= ch_b;
		end
		if (state_q == S_OLD) begin
			o_idx_q <= LETTER_W'(oidx_q);
			o_pres_q <= present[oidx_q];
			o_bits_q <= (present[oidx_q] && multi_q) ? cd_rdata.bits : '0;
			o_len_q <= (present[oidx_q] && multi_q) ? cd_rdata.len : '0;
			o_last_q <= last_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COUNT;
			sidx_q <= '0;
			seed_v_s1 <= 1'b0;
			next_q <= '0;
			p_q <= '0;
			first_q <= 1'b0;
			multi_q <= 1'b0;
			oidx_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_COUNT: begin
					if (accept && in_ch.end_of_text) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					sidx_q <= '0;
					state_q <= S_SEED;
				end
				S_SEED: begin
					if (sidx_q < LW'(ALPHABET_SIZE)) begin
						seed_v_s1 <= 1'b1;
						sidx_q <= sidx_q + 1'b1;
					end else begin
						seed_v_s1 <= 1'b0;
						if (!seed_v_s1) begin
							next_q <= NW'(ALPHABET_SIZE);
							state_q <= S_MERGE;
						end
					end
				end
				S_MERGE: begin
					if (lst_len > LW'(1)) begin
						next_q <= next_q + 1'b1;
					end else if (next_q == NW'(ALPHABET_SIZE)) begin
						multi_q <= 1'b0;
						oidx_q <= '0;
						state_q <= S_ORD;
					end else begin
						multi_q <= 1'b1;
						p_q <= next_q - 1'b1;
						first_q <= 1'b1;
						state_q <= S_CRD;
					end
				end
				S_CRD: begin
					state_q <= S_CWA;
				end
				S_CWA: begin
					state_q <= S_CWB;
				end
				S_CWB: begin
					first_q <= 1'b0;
					if (p_q == NW'(ALPHABET_SIZE)) begin
						oidx_q <= '0;
						state_q <= S_ORD;
					end else begin
						p_q <= p_q - 1'b1;
						state_q <= S_CRD;
					end
				end
				S_ORD: begin
					if (!out_v_q) begin
						state_q <= S_OLD;
					end
				end
				S_OLD: begin
					out_v_q <= 1'b1;
					if (last_out) begin
						state_q <= S_COUNT;
					end else begin
						oidx_q <= oidx_q + 1'b1;
						state_q <= S_ORD;
					end
				end
				default: begin
					state_q <= S_COUNT;
				end
			endcase
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.letter_index = o_idx_q;
	assign out_ch.present = o_pres_q;
	assign out_ch.code_bits = o_bits_q;
	assign out_ch.code_length = o_len_q;
	assign out_ch.last_entry = o_last_q;

	`HCTB_ASSERT_NOW(a_list_bound, 1'b1, lst_len <= LW'(ALPHABET_SIZE))
	`HCTB_ASSERT_NOW(a_child_order, state_q == S_CWA, ch_a < p_q && ch_b < p_q)
	`HCTB_ASSERT_NOW(a_out_free, state_q == S_OLD, !out_v_q)
	`HCTB_ASSERT_NEXT(a_counts_cleared, cnt_clear, present == '0)
endmodule
